// ===== rtl/core/positional_list_engine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared concurrent check forms, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// Check that holds at every edge outside reset.
`define PLE_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed in %m");

// Check that a condition implies a consequence in the next cycle.
`define PLE_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("check failed in %m");

// Check that a condition implies a consequence in the same cycle.
`define PLE_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("check failed in %m");

`endif

// ===== rtl/core/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional list engine package
// Command and status codes, cell control type and default sizing.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 5;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_OVERWRITE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // What every cell of the chain does on an update
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_WRITE  = 2'd3
    } cell_op_t;

    // Broadcast to all cells
    typedef struct packed {
        cell_op_t          op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] load;
    } cell_ctl_t;

endpackage

// ===== rtl/core/ple_cell.sv =====
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry; holds, takes a neighbor's entry, or loads.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int INDEX = 0
) (
    input  logic                      clk,
    input  ple_pkg::cell_ctl_t        ctl,
    input  logic [ple_pkg::DATA_W-1:0] left_data,
    input  logic [ple_pkg::DATA_W-1:0] right_data,
    output logic [ple_pkg::DATA_W-1:0] data
);
    import ple_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              at_pos;
    logic              above_pos;

    assign at_pos    = (int'(ctl.pos) == INDEX);
    assign above_pos = (int'(ctl.pos) < INDEX);

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (at_pos)
                begin
                    data_next = ctl.load;
                end
                else if (above_pos)
                begin
                    data_next = left_data;
                end
            end
            OP_REMOVE:
            begin
                // entry at pos is dropped; everything after it moves one toward the front
                if (at_pos || above_pos)
                begin
                    data_next = right_data;
                end
            end
            OP_WRITE:
            begin
                if (at_pos)
                begin
                    data_next = ctl.load;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/core/positional_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Positional list engine
// A command accepted at an edge shows its result, with done high, in the
// cycle that follows. Throughput: one command per cycle; every cell of the
// shift chain updates in parallel, so busy stays low.
// Reset: rst_n clears the entry count and done; entries stay undefined
// until an insert writes them. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`include "positional_list_engine_unit_macros.svh"

module positional_list_engine_unit #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command side
    input  logic                                start,
    output logic                                busy,
    input  logic [ple_pkg::CMD_W-1:0]           cmd,
    input  logic [ple_pkg::POS_W-1:0]           position,
    input  logic signed [ple_pkg::DATA_W-1:0]   value,
    // result side, one transfer per accepted command
    output logic                                done,
    output logic [ple_pkg::STATUS_W-1:0]        status,
    output logic signed [ple_pkg::DATA_W-1:0]   read_value,
    output logic [ple_pkg::COUNT_W-1:0]         count
);
    import ple_pkg::*;

    // count must hold CAPACITY itself; the index only needs CAPACITY-1
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    // common width for comparing position against count
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [DATA_W-1:0]   rd_reg;
    logic [DATA_W-1:0]   rd_next;

    logic                accept;
    logic [CMP_W-1:0]    cnt_x;
    logic [CMP_W-1:0]    pos_x;
    logic [IDX_W-1:0]    rd_idx;
    cell_ctl_t           ctl;

    logic [DATA_W-1:0]   entry_data [CAPACITY];

    // The chain updates in the accept cycle itself, so nothing ever waits.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign cnt_x  = CMP_W'(count_reg);
    assign pos_x  = CMP_W'(position);
    // only used when position is below count, so it fits the index
    assign rd_idx = pos_x[IDX_W-1:0];

    // ------------------------------------------------------------------------
    // Command decode: range and full checks, chain control, result values.
    // Insert allows position == count (append); the range test wins over
    // the full test. All other commands need position below count, which
    // also rejects anything on an empty list.
    // ------------------------------------------------------------------------
    always_comb
    begin
        ctl.op      = OP_HOLD;
        ctl.pos     = position;
        ctl.load    = value;
        status_next = ST_DONE;
        rd_next     = '0;
        count_next  = count_reg;

        if (accept)
        begin
            if (cmd == CMD_INSERT)
            begin
                if (pos_x > cnt_x)
                begin
                    status_next = ST_RANGE;
                end
                else if (cnt_x == CMP_W'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.op     = OP_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else if (pos_x >= cnt_x)
            begin
                status_next = ST_RANGE;
            end
            else
            begin
                case (cmd)
                    CMD_REMOVE:
                    begin
                        ctl.op     = OP_REMOVE;
                        count_next = count_reg - CNT_W'(1);
                    end
                    CMD_READ:
                    begin
                        rd_next = entry_data[rd_idx];
                    end
                    CMD_OVERWRITE:
                    begin
                        ctl.op = OP_WRITE;
                    end
                    default:
                    begin
                        ctl.op = OP_HOLD;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Cell chain: cell i sees cell i-1 on the left and cell i+1 on the right.
    // The front cell never takes from the left (insert at zero loads it);
    // the last cell takes its own value on a remove, which is past the end.
    // ------------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (i == 0)
        begin : g_front
            assign left_in = '0;
        end
        else
        begin : g_mid_l
            assign left_in = entry_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_back
            assign right_in = entry_data[i];
        end
        else
        begin : g_mid_r
            assign right_in = entry_data[i+1];
        end

        ple_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (entry_data[i])
        );
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rd_reg     <= rd_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = rd_reg;
    assign count      = cnt_x[COUNT_W-1:0];

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    `PLE_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY))
    `PLE_ASSERT_NEXT(a_done_follows, accept, done)
    `PLE_ASSERT_SAME(a_full_at_cap, done && status == ST_FULL, count_reg == CNT_W'(CAPACITY))
    `PLE_ASSERT_SAME(a_read_only_ok, done && read_value != '0, status == ST_DONE)

endmodule
